/* rtl/core/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// qrm_pkg: shared types and constants for the quaternion to rotation matrix
// Field widths, intermediate widths, matrix entry indexes and the product
// bundle that leaves the multiplier stage.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int IN_W        = 16;           // one quaternion component
  localparam int OUT_W       = 16;           // one matrix entry
  localparam int NENT        = 9;            // entries of the 3x3 matrix
  localparam int IN_TDATA_W  = 4 * IN_W;
  localparam int OUT_TDATA_W = NENT * OUT_W;
  localparam int PROD_W      = 2 * IN_W;     // 16x16 signed product
  localparam int N_W         = PROD_W + 1;   // sum of four squares
  localparam int NUM_W       = PROD_W + 2;   // signed numerator, up to +-2^32
  localparam int REM_W       = N_W + 1;      // partial remainder, below 2n

  // Row-major matrix entry indexes
  localparam int E_M00 = 0;
  localparam int E_M01 = 1;
  localparam int E_M02 = 2;
  localparam int E_M10 = 3;
  localparam int E_M11 = 4;
  localparam int E_M12 = 5;
  localparam int E_M20 = 6;
  localparam int E_M21 = 7;
  localparam int E_M22 = 8;

  typedef logic signed [IN_W-1:0]   comp_t;
  typedef logic signed [PROD_W-1:0] prod_w_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic [N_W-1:0]           norm_t;
  typedef logic [REM_W-1:0]         rem_t;

  typedef struct packed {
    prod_w_t rr;
    prod_w_t ii;
    prod_w_t jj;
    prod_w_t kk;
    prod_w_t ij;
    prod_w_t ik;
    prod_w_t jk;
    prod_w_t ir;
    prod_w_t jr;
    prod_w_t kr;
  } prod_t;

  // Sign-extend a product to numerator width
  function automatic num_t ext_prod(input prod_w_t p);
    return num_t'(p);
  endfunction

  // Double a numerator
  function automatic num_t dbl(input num_t v);
    return {v[NUM_W-2:0], 1'b0};
  endfunction

endpackage

/* rtl/core/quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix: quaternion to 3x3 rotation matrix
// Normalizes by the sum of squares, so no square root; entries are rounded
// to nearest (ties away from zero) with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                         | tuser
//  --------+-----------+-------------------------------+-----------------
//  in_     | sink      | q_real, q_i, q_j, q_k (16 ea) | none
//  out_    | source    | m00 .. m22 (16 each)          | zero_quaternion
//
// Registers from input transfer to out_tvalid: one multiplier stage, one
// sum stage, one magnitude stage, FRAC_BITS + 2 restoring-division stages
// (one quotient bit per stage, nine lanes), and the output register. One
// item is taken every cycle while the skid register is empty.
// Reset clears the valid bits of the pipeline, output and skid registers.
// On an output stall the skid register absorbs one result, then the whole
// pipeline freezes until the skid register drains.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix
  import qrm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // q_real, q_i, q_j, q_k (lowest first)
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // m00, m01, m02, m10 .. m22 (lowest first)
  output logic                   out_tuser   // zero_quaternion
);

  // Quotient bits: one above one (for the rounding bit) plus FRAC_BITS + 1
  localparam int DIV_STEPS = FRAC_BITS + 2;
  localparam int PIPE      = DIV_STEPS + 3;
  localparam int ONE_I     = 1 << FRAC_BITS;
  // Largest magnitudes after limiting to one and to the 16-bit range
  localparam int POS_CAP_I = (ONE_I > 32767) ? 32767 : ONE_I;
  localparam int NEG_CAP_I = (ONE_I > 32768) ? 32768 : ONE_I;

  typedef logic [DIV_STEPS-1:0] quo_t;

  localparam quo_t             POS_CAP_Q = quo_t'(POS_CAP_I);
  localparam quo_t             NEG_CAP_Q = quo_t'(NEG_CAP_I);
  localparam logic [OUT_W-1:0] ONE16     = OUT_W'(POS_CAP_I);

  // --------------------------------------------------------------------------
  // Flow control: the pipeline advances as one while the skid register is empty
  // --------------------------------------------------------------------------
  logic            en;
  logic [PIPE-1:0] v_r;
  logic            out_v_r;
  logic            skid_v_r;
  logic            pv;

  assign en        = ~skid_v_r;
  assign in_tready = en;
  assign pv        = v_r[PIPE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[PIPE-2:0], in_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: the ten products
  // --------------------------------------------------------------------------
  comp_t q_real, q_i, q_j, q_k;
  prod_t prod_r;

  assign q_real = in_tdata[IN_W-1:0];
  assign q_i    = in_tdata[2*IN_W-1:IN_W];
  assign q_j    = in_tdata[3*IN_W-1:2*IN_W];
  assign q_k    = in_tdata[4*IN_W-1:3*IN_W];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r.rr <= q_real * q_real;
      prod_r.ii <= q_i * q_i;
      prod_r.jj <= q_j * q_j;
      prod_r.kk <= q_k * q_k;
      prod_r.ij <= q_i * q_j;
      prod_r.ik <= q_i * q_k;
      prod_r.jk <= q_j * q_k;
      prod_r.ir <= q_i * q_real;
      prod_r.jr <= q_j * q_real;
      prod_r.kr <= q_k * q_real;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: norm and the nine signed numerators
  // --------------------------------------------------------------------------
  norm_t norm_r;
  num_t  num_r [NENT];

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r <= norm_t'($unsigned(prod_r.rr)) + norm_t'($unsigned(prod_r.ii))
              + norm_t'($unsigned(prod_r.jj)) + norm_t'($unsigned(prod_r.kk));
      // Diagonal: n - 2(a^2 + b^2) folds into a signed sum of squares
      num_r[E_M00] <= ext_prod(prod_r.rr) + ext_prod(prod_r.ii)
                    - ext_prod(prod_r.jj) - ext_prod(prod_r.kk);
      num_r[E_M11] <= ext_prod(prod_r.rr) - ext_prod(prod_r.ii)
                    + ext_prod(prod_r.jj) - ext_prod(prod_r.kk);
      num_r[E_M22] <= ext_prod(prod_r.rr) - ext_prod(prod_r.ii)
                    - ext_prod(prod_r.jj) + ext_prod(prod_r.kk);
      num_r[E_M01] <= dbl(ext_prod(prod_r.ij) - ext_prod(prod_r.kr));
      num_r[E_M02] <= dbl(ext_prod(prod_r.ik) + ext_prod(prod_r.jr));
      num_r[E_M10] <= dbl(ext_prod(prod_r.ij) + ext_prod(prod_r.kr));
      num_r[E_M12] <= dbl(ext_prod(prod_r.jk) - ext_prod(prod_r.ir));
      num_r[E_M20] <= dbl(ext_prod(prod_r.ik) - ext_prod(prod_r.jr));
      num_r[E_M21] <= dbl(ext_prod(prod_r.jk) + ext_prod(prod_r.ir));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 and the division stages. Every numerator magnitude is at most n,
  // so the quotient of mag * 2^(FRAC_BITS+1) / n has DIV_STEPS bits; the
  // first step compares mag itself against n.
  // --------------------------------------------------------------------------
  rem_t            rem_r  [DIV_STEPS][NENT];
  quo_t            quo_r  [1:DIV_STEPS][NENT];
  norm_t           dn_r   [DIV_STEPS];
  logic [NENT-1:0] neg_r  [DIV_STEPS+1];
  logic            dz_r   [DIV_STEPS+1];
  logic [NENT-1:0] ge     [DIV_STEPS];

  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      for (int e = 0; e < NENT; e++) begin
        ge[s][e] = rem_r[s][e] >= rem_t'(dn_r[s]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Magnitude stage
      dn_r[0] <= norm_r;
      dz_r[0] <= (norm_r == '0);
      for (int e = 0; e < NENT; e++) begin
        neg_r[0][e] <= num_r[e][NUM_W-1];
        rem_r[0][e] <= num_r[e][NUM_W-1] ? rem_t'(-num_r[e]) : rem_t'(num_r[e]);
      end
      // Restoring division, one quotient bit per stage
      for (int s = 0; s < DIV_STEPS; s++) begin
        neg_r[s+1] <= neg_r[s];
        dz_r[s+1]  <= dz_r[s];
      end
      for (int s = 0; s < DIV_STEPS - 1; s++) begin
        dn_r[s+1] <= dn_r[s];
        for (int e = 0; e < NENT; e++) begin
          rem_r[s+1][e] <= (ge[s][e] ? rem_r[s][e] - rem_t'(dn_r[s]) : rem_r[s][e]) << 1;
        end
      end
      for (int e = 0; e < NENT; e++) begin
        quo_r[1][e] <= quo_t'(ge[0][e]);
      end
      for (int s = 1; s < DIV_STEPS; s++) begin
        for (int e = 0; e < NENT; e++) begin
          quo_r[s+1][e] <= {quo_r[s][e][DIV_STEPS-2:0], ge[s][e]};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Rounding, limiting, sign and the zero-quaternion override. The extra
  // quotient bit carries the half: (t + 1) / 2 rounds ties away from zero.
  // --------------------------------------------------------------------------
  logic [OUT_TDATA_W-1:0] res_data;
  logic                   res_zero;

  always_comb begin
    logic [DIV_STEPS:0] rnd;
    quo_t               rq;
    quo_t               cap;
    quo_t               mc;
    logic [OUT_W-1:0]   m16;
    logic [OUT_W-1:0]   val;
    logic               diag;
    res_zero = dz_r[DIV_STEPS];
    for (int e = 0; e < NENT; e++) begin
      rnd  = {1'b0, quo_r[DIV_STEPS][e]} + (DIV_STEPS+1)'(1);
      rq   = rnd[DIV_STEPS:1];
      cap  = neg_r[DIV_STEPS][e] ? NEG_CAP_Q : POS_CAP_Q;
      mc   = (rq > cap) ? cap : rq;
      m16  = OUT_W'(mc);
      val  = neg_r[DIV_STEPS][e] ? (~m16 + OUT_W'(1)) : m16;
      diag = (e == E_M00) || (e == E_M11) || (e == E_M22);
      if (res_zero) begin
        res_data[e*OUT_W +: OUT_W] = diag ? ONE16 : '0;
      end else begin
        res_data[e*OUT_W +: OUT_W] = val;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid register behind it
  // --------------------------------------------------------------------------
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_zero_r;
  logic [OUT_TDATA_W-1:0] skid_data_r;
  logic                   skid_zero_r;
  logic                   out_stuck;

  assign out_stuck = out_v_r & ~out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      // Drain the skid register into the output register
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (pv) begin
      if (out_stuck) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
        out_zero_r <= skid_zero_r;
      end
    end else if (pv) begin
      if (out_stuck) begin
        skid_data_r <= res_data;
        skid_zero_r <= res_zero;
      end else begin
        out_data_r <= res_data;
        out_zero_r <= res_zero;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

`ifndef SYNTHESIS
  // A held skid result always has a result in front of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register is empty");

  // A zero quaternion leaves the identity matrix
  a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[E_M00*OUT_W +: OUT_W] == ONE16) &&
      (out_tdata[E_M11*OUT_W +: OUT_W] == ONE16) &&
      (out_tdata[E_M22*OUT_W +: OUT_W] == ONE16) &&
      (out_tdata[E_M01*OUT_W +: OUT_W] == '0) &&
      (out_tdata[E_M02*OUT_W +: OUT_W] == '0) &&
      (out_tdata[E_M10*OUT_W +: OUT_W] == '0) &&
      (out_tdata[E_M12*OUT_W +: OUT_W] == '0) &&
      (out_tdata[E_M20*OUT_W +: OUT_W] == '0) &&
      (out_tdata[E_M21*OUT_W +: OUT_W] == '0))
    else $error("zero quaternion did not give the identity matrix");

  // Entries m00 and m12 stay within plus or minus one
  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[E_M00*OUT_W +: OUT_W]) <= POS_CAP_I) &&
      ($signed(out_tdata[E_M00*OUT_W +: OUT_W]) >= -NEG_CAP_I) &&
      ($signed(out_tdata[E_M12*OUT_W +: OUT_W]) <= POS_CAP_I) &&
      ($signed(out_tdata[E_M12*OUT_W +: OUT_W]) >= -NEG_CAP_I))
    else $error("matrix entry outside plus or minus one");
`endif

endmodule
